>>> design/lrtc_pkg.sv
// ============================================================================
// lrtc_pkg: shared types and constants of the link retry timeout controller
// Holds the transfer payload structs, the code enums and the reset values of
// the configuration registers.
// ============================================================================
package lrtc_pkg;

    localparam int ID_BITS   = 8;
    localparam int STAT_BITS = 16;
    localparam int TIME_BITS = 32;
    localparam int TMO_BITS  = 20;
    localparam int RETRY_BITS = 7;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [TMO_BITS-1:0]   MASTER_TMO_RESET   = 20'd2000;
    localparam logic [TMO_BITS-1:0]   SLAVE_TMO_RESET    = 20'd10000;
    localparam logic [RETRY_BITS-1:0] MASTER_RETRY_RESET = 7'd50;
    localparam logic [RETRY_BITS-1:0] SLAVE_RETRY_RESET  = 7'd10;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IS_MASTER    = 3'd0,
        CFG_MASTER_TMO   = 3'd1,
        CFG_SLAVE_TMO    = 3'd2,
        CFG_MASTER_RETRY = 3'd3,
        CFG_SLAVE_RETRY  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_READY     = 2'd0,
        PH_SENDING   = 2'd1,
        PH_RECEIVING = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        FN_POLL    = 2'd0,
        FN_TX_DONE = 2'd1,
        FN_START   = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        RX_INCOMPLETE = 2'd0,
        RX_INVALID    = 2'd1,
        RX_VALID      = 2'd2
    } t_rx_status;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_NEW    = 2'd1,
        ACT_RESEND = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_CONNECTED = 2'd1,
        EV_RESET     = 2'd2
    } t_event;

    typedef struct packed {
        logic [1:0]           func;
        logic [TIME_BITS-1:0] now_us;
        logic [1:0]           rx_status;
        logic [ID_BITS-1:0]   rx_transfer_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           link_state;
        logic [1:0]           send_action;
        logic [ID_BITS-1:0]   tx_transfer_id;
        logic                 deliver_packet;
        logic                 rx_restart;
        logic                 connected;
        logic [1:0]           link_event;
        logic [STAT_BITS-1:0] timeout_total;
        logic [STAT_BITS-1:0] reset_total;
        logic [STAT_BITS-1:0] repeat_total;
        logic [STAT_BITS-1:0] rx_packet_total;
        logic [STAT_BITS-1:0] tx_done_total;
    } t_out_item;

endpackage

>>> design/link_retry_timeout_controller.sv
// ============================================================================
// link_retry_timeout_controller: half-duplex ping-pong link control
// Tracks ready/sending/receiving, retries on timeout or bad packets, detects
// repeated packets and keeps wrapping statistics.
// ============================================================================
// Each input transfer is one event (poll, transmit finished or start link).
// It is judged in the cycle it is accepted, the link state is updated at
// that clock edge and one result transfer is loaded into the output
// register. The only path is the 32-bit elapsed-time subtract and compare
// feeding the state and result registers, so a new event can be accepted
// in every cycle while results drain. The output register holds a
// result until it is taken, and the input side stays ready while the result
// drains in the same cycle, so a stall on the output side only blocks input
// while a result is actually waiting. Configuration registers are read on
// every event, so a role change takes effect on the next accepted transfer.
module link_retry_timeout_controller
    import lrtc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    // event input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in,
    // result output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out
);

    // Configuration registers.
    logic                  r_is_master;
    logic [TMO_BITS-1:0]   r_master_tmo;
    logic [TMO_BITS-1:0]   r_slave_tmo;
    logic [RETRY_BITS-1:0] r_master_retry;
    logic [RETRY_BITS-1:0] r_slave_retry;

    // Link state.
    t_phase                r_phase,       n_phase;
    logic [RETRY_BITS-1:0] r_fail_count,  n_fail_count;
    logic                  r_link_up,     n_link_up;
    logic                  r_fresh,       n_fresh;
    logic [ID_BITS-1:0]    r_prev_rx_id,  n_prev_rx_id;
    logic [ID_BITS-1:0]    r_send_id,     n_send_id;
    logic [TIME_BITS-1:0]  r_rx_start,    n_rx_start;
    logic [STAT_BITS-1:0]  r_stat_tmo,    n_stat_tmo;
    logic [STAT_BITS-1:0]  r_stat_resets, n_stat_resets;
    logic [STAT_BITS-1:0]  r_stat_repeat, n_stat_repeat;
    logic [STAT_BITS-1:0]  r_stat_rx,     n_stat_rx;
    logic [STAT_BITS-1:0]  r_stat_txd,    n_stat_txd;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic                  in_fire;
    logic [TIME_BITS-1:0]  elapsed;
    logic [TMO_BITS-1:0]   tmo_limit;
    logic [RETRY_BITS-1:0] retry_limit;
    logic [RETRY_BITS:0]   fail_next;
    logic                  timed_out;
    logic                  fail;
    logic                  do_send;
    t_action               action;
    logic                  deliver;
    logic                  restart;
    t_event                link_ev;

    // Input is taken whenever the output register is empty or drains now.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Role-dependent limits and the wrapping elapsed time since receive start.
    assign tmo_limit   = r_is_master ? r_master_tmo   : r_slave_tmo;
    assign retry_limit = r_is_master ? r_master_retry : r_slave_retry;
    assign elapsed     = i_in.now_us - r_rx_start;
    assign timed_out   = elapsed > {{(TIME_BITS-TMO_BITS){1'b0}}, tmo_limit};
    assign fail_next   = {1'b0, r_fail_count} + {{RETRY_BITS{1'b0}}, 1'b1};

    always_comb begin
        n_phase       = r_phase;
        n_fail_count  = r_fail_count;
        n_link_up     = r_link_up;
        n_fresh       = r_fresh;
        n_prev_rx_id  = r_prev_rx_id;
        n_send_id     = r_send_id;
        n_rx_start    = r_rx_start;
        n_stat_tmo    = r_stat_tmo;
        n_stat_resets = r_stat_resets;
        n_stat_repeat = r_stat_repeat;
        n_stat_rx     = r_stat_rx;
        n_stat_txd    = r_stat_txd;
        fail          = 1'b0;
        do_send       = 1'b0;
        deliver       = 1'b0;
        restart       = 1'b0;
        link_ev       = EV_NONE;
        action        = ACT_NONE;

        case (i_in.func)
            FN_POLL: begin
                if (r_phase == PH_READY) begin
                    do_send = 1'b1;
                end else if (r_phase == PH_RECEIVING) begin
                    if (i_in.rx_status == RX_INVALID) begin
                        fail = 1'b1;
                    end else if (i_in.rx_status == RX_VALID) begin
                        n_stat_rx = r_stat_rx + 1'b1;
                        do_send   = 1'b1;
                        if (i_in.rx_transfer_id == r_prev_rx_id) begin
                            // Peer missed our last packet: repeat it.
                            n_stat_repeat = r_stat_repeat + 1'b1;
                        end else begin
                            n_prev_rx_id = i_in.rx_transfer_id;
                            if (!r_link_up) begin
                                n_link_up = 1'b1;
                                link_ev   = EV_CONNECTED;
                            end
                            deliver      = 1'b1;
                            n_fresh      = 1'b1;
                            n_fail_count = '0;
                        end
                    end else if (timed_out) begin
                        // Incomplete packet (or the unused status code).
                        n_stat_tmo = r_stat_tmo + 1'b1;
                        fail       = 1'b1;
                    end
                end
            end
            FN_TX_DONE: begin
                n_stat_txd = r_stat_txd + 1'b1;
                n_phase    = PH_RECEIVING;
                n_rx_start = i_in.now_us;
            end
            FN_START: begin
                if (r_is_master) begin
                    n_phase = PH_READY;
                end else begin
                    n_phase    = PH_RECEIVING;
                    n_rx_start = i_in.now_us;
                end
            end
            default: begin
            end
        endcase

        // Failure: count a retry, drop the connection once past the limit.
        if (fail) begin
            if (fail_next > {1'b0, retry_limit}) begin
                n_link_up     = 1'b0;
                n_fresh       = 1'b1;
                n_fail_count  = '0;
                n_stat_resets = r_stat_resets + 1'b1;
                link_ev       = EV_RESET;
            end else begin
                n_fail_count = fail_next[RETRY_BITS-1:0];
            end
            if (r_is_master) begin
                n_phase = PH_READY;
            end else begin
                n_phase    = PH_RECEIVING;
                n_rx_start = i_in.now_us;
                restart    = 1'b1;
            end
        end

        // Send: a fresh packet takes the next id, otherwise resend the last.
        if (do_send) begin
            n_phase = PH_SENDING;
            if (n_fresh) begin
                n_fresh   = 1'b0;
                n_send_id = r_send_id + 1'b1;
                action    = ACT_NEW;
            end else begin
                action = ACT_RESEND;
            end
        end

        n_out.link_state      = n_phase;
        n_out.send_action     = action;
        n_out.tx_transfer_id  = n_send_id;
        n_out.deliver_packet  = deliver;
        n_out.rx_restart      = restart;
        n_out.connected       = n_link_up;
        n_out.link_event      = link_ev;
        n_out.timeout_total   = n_stat_tmo;
        n_out.reset_total     = n_stat_resets;
        n_out.repeat_total    = n_stat_repeat;
        n_out.rx_packet_total = n_stat_rx;
        n_out.tx_done_total   = n_stat_txd;
    end

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_master    <= 1'b0;
            r_master_tmo   <= MASTER_TMO_RESET;
            r_slave_tmo    <= SLAVE_TMO_RESET;
            r_master_retry <= MASTER_RETRY_RESET;
            r_slave_retry  <= SLAVE_RETRY_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IS_MASTER:    r_is_master    <= i_cfg_wdata[0];
                CFG_MASTER_TMO:   r_master_tmo   <= i_cfg_wdata[TMO_BITS-1:0];
                CFG_SLAVE_TMO:    r_slave_tmo    <= i_cfg_wdata[TMO_BITS-1:0];
                CFG_MASTER_RETRY: r_master_retry <= i_cfg_wdata[RETRY_BITS-1:0];
                CFG_SLAVE_RETRY:  r_slave_retry  <= i_cfg_wdata[RETRY_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Link state updates only on an accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_RECEIVING;
            r_fail_count  <= '0;
            r_link_up     <= 1'b0;
            r_fresh       <= 1'b1;
            r_prev_rx_id  <= '0;
            r_send_id     <= '0;
            r_rx_start    <= '0;
            r_stat_tmo    <= '0;
            r_stat_resets <= '0;
            r_stat_repeat <= '0;
            r_stat_rx     <= '0;
            r_stat_txd    <= '0;
        end else if (in_fire) begin
            r_phase       <= n_phase;
            r_fail_count  <= n_fail_count;
            r_link_up     <= n_link_up;
            r_fresh       <= n_fresh;
            r_prev_rx_id  <= n_prev_rx_id;
            r_send_id     <= n_send_id;
            r_rx_start    <= n_rx_start;
            r_stat_tmo    <= n_stat_tmo;
            r_stat_resets <= n_stat_resets;
            r_stat_repeat <= n_stat_repeat;
            r_stat_rx     <= n_stat_rx;
            r_stat_txd    <= n_stat_txd;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    // Every accepted event leaves a result waiting.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_out_valid)
        else $error("accepted transfer produced no result");

    // A newly built packet always carries the next id.
    a_new_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (n_out.send_action == ACT_NEW)
        |=> r_send_id == ID_BITS'($past(r_send_id) + 1'b1))
        else $error("new packet id is not the previous id plus one");

    // A delivered packet means the link is up and a fresh reply goes out.
    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.deliver_packet
        |-> o_out.connected && (o_out.send_action == ACT_NEW))
        else $error("delivered packet without connection or fresh reply");

    // A connection reset leaves the link down with a clean retry count.
    a_reset_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (n_out.link_event == EV_RESET)
        |=> !r_link_up && (r_fail_count == '0) && r_fresh)
        else $error("connection reset left stale link state");

    // Link state moves only on an accepted transfer.
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire |=> $stable(r_phase) && $stable(r_send_id))
        else $error("link state changed without an accepted transfer");

endmodule

>>> tb/lrtc_result_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// lrtc_result_checker: result prediction and comparison for the link controller
// Mirrors the configuration writes, predicts one result per accepted event
// transfer and checks every result transfer against the oldest prediction.
// ============================================================================
module lrtc_result_checker
    import lrtc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  t_in_item                 i_in,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  t_out_item                i_out,
    output int                       o_fail_count,
    output int                       o_pending
);

    // Mirrored configuration registers.
    logic                  role_master;
    logic [TMO_BITS-1:0]   tmo_master;
    logic [TMO_BITS-1:0]   tmo_slave;
    logic [RETRY_BITS-1:0] retry_master;
    logic [RETRY_BITS-1:0] retry_slave;

    // Predicted link state and statistics.
    t_phase                link_phase;
    logic [RETRY_BITS-1:0] fails;
    logic                  up;
    logic                  fresh;
    logic [ID_BITS-1:0]    last_rx_id;
    logic [ID_BITS-1:0]    tx_id;
    logic [TIME_BITS-1:0]  rx_t0;
    logic [STAT_BITS-1:0]  n_timeouts;
    logic [STAT_BITS-1:0]  n_resets;
    logic [STAT_BITS-1:0]  n_repeats;
    logic [STAT_BITS-1:0]  n_rx_pkts;
    logic [STAT_BITS-1:0]  n_tx_done;

    // Per-event outputs of the prediction.
    t_action               step_action;
    logic                  step_deliver;
    logic                  step_restart;
    t_event                step_event;

    t_out_item             predicted_results[$];
    int                    mismatches = 0;

    task launch_packet();
        link_phase = PH_SENDING;
        if (fresh) begin
            fresh       = 1'b0;
            tx_id       = tx_id + 1'b1;
            step_action = ACT_NEW;
        end else begin
            step_action = ACT_RESEND;
        end
    endtask

    task rx_failure(input logic [TIME_BITS-1:0] now);
        logic [RETRY_BITS-1:0] limit;
        limit = role_master ? retry_master : retry_slave;
        if ({1'b0, fails} + 8'd1 > {1'b0, limit}) begin
            up         = 1'b0;
            fresh      = 1'b1;
            fails      = '0;
            n_resets   = n_resets + 1'b1;
            step_event = EV_RESET;
        end else begin
            fails = fails + 1'b1;
        end
        if (role_master) begin
            link_phase = PH_READY;
        end else begin
            link_phase   = PH_RECEIVING;
            rx_t0        = now;
            step_restart = 1'b1;
        end
    endtask

    task link_advance(input t_in_item ev, output t_out_item res);
        logic [TIME_BITS-1:0] elapsed;
        logic [TMO_BITS-1:0]  tmo;
        step_action  = ACT_NONE;
        step_deliver = 1'b0;
        step_restart = 1'b0;
        step_event   = EV_NONE;
        case (ev.func)
            FN_POLL: begin
                if (link_phase == PH_READY) begin
                    launch_packet();
                end else if (link_phase == PH_RECEIVING) begin
                    if (ev.rx_status == RX_INVALID) begin
                        rx_failure(ev.now_us);
                    end else if (ev.rx_status == RX_VALID) begin
                        n_rx_pkts = n_rx_pkts + 1'b1;
                        if (ev.rx_transfer_id == last_rx_id) begin
                            n_repeats = n_repeats + 1'b1;
                            launch_packet();
                        end else begin
                            last_rx_id = ev.rx_transfer_id;
                            if (!up) begin
                                up         = 1'b1;
                                step_event = EV_CONNECTED;
                            end
                            step_deliver = 1'b1;
                            fresh        = 1'b1;
                            fails        = '0;
                            launch_packet();
                        end
                    end else begin
                        // Incomplete or the unused status code: only the
                        // wrapping elapsed time matters.
                        elapsed = ev.now_us - rx_t0;
                        tmo     = role_master ? tmo_master : tmo_slave;
                        if (elapsed > {{(TIME_BITS-TMO_BITS){1'b0}}, tmo}) begin
                            n_timeouts = n_timeouts + 1'b1;
                            rx_failure(ev.now_us);
                        end
                    end
                end
            end
            FN_TX_DONE: begin
                n_tx_done  = n_tx_done + 1'b1;
                link_phase = PH_RECEIVING;
                rx_t0      = ev.now_us;
            end
            FN_START: begin
                if (role_master) begin
                    link_phase = PH_READY;
                end else begin
                    link_phase = PH_RECEIVING;
                    rx_t0      = ev.now_us;
                end
            end
            default: ;
        endcase
        res.link_state      = link_phase;
        res.send_action     = step_action;
        res.tx_transfer_id  = tx_id;
        res.deliver_packet  = step_deliver;
        res.rx_restart      = step_restart;
        res.connected       = up;
        res.link_event      = step_event;
        res.timeout_total   = n_timeouts;
        res.reset_total     = n_resets;
        res.repeat_total    = n_repeats;
        res.rx_packet_total = n_rx_pkts;
        res.tx_done_total   = n_tx_done;
    endtask

    task check_field(input string nm, input logic [31:0] want, input logic [31:0] got,
                     inout bit bad);
        if (want !== got) begin
            if (mismatches < 10) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, nm, want, got);
            end
            bad = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        bit        bad;
        if (!i_rst_n) begin
            role_master  = 1'b0;
            tmo_master   = MASTER_TMO_RESET;
            tmo_slave    = SLAVE_TMO_RESET;
            retry_master = MASTER_RETRY_RESET;
            retry_slave  = SLAVE_RETRY_RESET;
            link_phase   = PH_RECEIVING;
            fails        = '0;
            up           = 1'b0;
            fresh        = 1'b1;
            last_rx_id   = '0;
            tx_id        = '0;
            rx_t0        = '0;
            n_timeouts   = '0;
            n_resets     = '0;
            n_repeats    = '0;
            n_rx_pkts    = '0;
            n_tx_done    = '0;
            predicted_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: result transfer with nothing outstanding", $realtime);
                    end
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    bad  = 1'b0;
                    check_field("link_state", 32'(want.link_state),
                                32'(i_out.link_state), bad);
                    check_field("send_action", 32'(want.send_action),
                                32'(i_out.send_action), bad);
                    check_field("tx_transfer_id", 32'(want.tx_transfer_id),
                                32'(i_out.tx_transfer_id), bad);
                    check_field("deliver_packet", 32'(want.deliver_packet),
                                32'(i_out.deliver_packet), bad);
                    check_field("rx_restart", 32'(want.rx_restart),
                                32'(i_out.rx_restart), bad);
                    check_field("connected", 32'(want.connected),
                                32'(i_out.connected), bad);
                    check_field("link_event", 32'(want.link_event),
                                32'(i_out.link_event), bad);
                    check_field("timeout_total", 32'(want.timeout_total),
                                32'(i_out.timeout_total), bad);
                    check_field("reset_total", 32'(want.reset_total),
                                32'(i_out.reset_total), bad);
                    check_field("repeat_total", 32'(want.repeat_total),
                                32'(i_out.repeat_total), bad);
                    check_field("rx_packet_total", 32'(want.rx_packet_total),
                                32'(i_out.rx_packet_total), bad);
                    check_field("tx_done_total", 32'(want.tx_done_total),
                                32'(i_out.tx_done_total), bad);
                    if (bad) begin
                        mismatches++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_IS_MASTER:    role_master  = i_cfg_wdata[0];
                    CFG_MASTER_TMO:   tmo_master   = i_cfg_wdata[TMO_BITS-1:0];
                    CFG_SLAVE_TMO:    tmo_slave    = i_cfg_wdata[TMO_BITS-1:0];
                    CFG_MASTER_RETRY: retry_master = i_cfg_wdata[RETRY_BITS-1:0];
                    CFG_SLAVE_RETRY:  retry_slave  = i_cfg_wdata[RETRY_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                link_advance(i_in, want);
                predicted_results.push_back(want);
            end
        end
        o_pending    <= predicted_results.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: regression bench for the link retry timeout controller
// Drives directed and random link events through the valid/ready channels,
// reprograms the role, timeouts and retry limits between phases, and lets a
// separate checker predict and compare every result transfer.
// ============================================================================
module tb;
    import lrtc_pkg::*;

    // Codes the package leaves unnamed but the fields still allow.
    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam logic [1:0] RX_UNUSED = 2'd3;

    // Cycles without any transfer before the run is declared hung. The
    // slowest legal stretch is a sender gap plus a receiver stall or the
    // long receiver hold-off, so this is many times over.
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PHASE_EVENTS    = 84;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    t_in_item                 in_item   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    t_out_item                out_item;

    int                       fail_count;
    int                       pending;

    // Stimulus bookkeeping shared by the sender tasks.
    bit                       sender_idles   = 1'b1;
    bit                       receiver_idles = 1'b1;
    bit                       hold_off_req   = 1'b0;
    bit                       role_master    = 1'b0;
    int                       events_sent    = 0;
    int                       quiet_cycles   = 0;
    logic [TIME_BITS-1:0]     clock_us       = '0;
    logic [ID_BITS-1:0]       peer_id        = '0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    link_retry_timeout_controller uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    lrtc_result_checker result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offers one event and returns at the clock edge where it is taken.
    // Valid stays high from one transfer to the next unless a gap is drawn,
    // so back-to-back events never lower and raise valid in the same step.
    task automatic push_event(input logic [1:0] fn, input logic [TIME_BITS-1:0] t,
                              input logic [1:0] st, input logic [ID_BITS-1:0] id);
        t_in_item ev;
        int       gap;
        ev.func           = fn;
        ev.now_us         = t;
        ev.rx_status      = st;
        ev.rx_transfer_id = id;
        if (sender_idles && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        do @(posedge clk); while (!(in_valid && in_ready));
        if (fn != FN_UNUSED) begin
            events_sent++;
        end
    endtask

    // Drops valid and waits until every predicted result has been taken.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    // Writes all five registers in consecutive cycles; the write enable is
    // lowered only once the last one has gone in.
    task automatic program_link(input logic m, input logic [TMO_BITS-1:0] mt,
                                input logic [TMO_BITS-1:0] st,
                                input logic [RETRY_BITS-1:0] mr,
                                input logic [RETRY_BITS-1:0] sr);
        role_master = m;
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IS_MASTER;
        cfg_wdata <= {{(CFG_DATA_BITS-1){1'b0}}, m};
        @(posedge clk);
        cfg_index <= CFG_MASTER_TMO;
        cfg_wdata <= mt;
        @(posedge clk);
        cfg_index <= CFG_SLAVE_TMO;
        cfg_wdata <= st;
        @(posedge clk);
        cfg_index <= CFG_MASTER_RETRY;
        cfg_wdata <= {{(CFG_DATA_BITS-RETRY_BITS){1'b0}}, mr};
        @(posedge clk);
        cfg_index <= CFG_SLAVE_RETRY;
        cfg_wdata <= {{(CFG_DATA_BITS-RETRY_BITS){1'b0}}, sr};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: ready comes in random bursts. When the stimulus asks for
    // a hold-off, ready stays low for a long counted stretch so the output
    // register fills and the block has to stall its input.
    initial begin : result_sink
        int span;
        do @(posedge clk); while (!rst_n);
        forever begin
            span = $urandom_range(1, 18);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                if (receiver_idles && $urandom_range(0, 2) == 0) begin
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                end
                repeat (span) @(posedge clk);
            end
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("link_retry_timeout_controller regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int                    p;
        int                    span;
        int                    quota;
        int                    polls;
        int                    ending;
        logic                  m;
        logic [TMO_BITS-1:0]   mt;
        logic [TMO_BITS-1:0]   st;
        logic [RETRY_BITS-1:0] mr;
        logic [RETRY_BITS-1:0] sr;
        logic [TIME_BITS-1:0]  t;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset configuration: slave role, 10000 us
        // timeout and a retry limit of 10.
        // A fresh poll at time zero sees no elapsed time.
        push_event(FN_POLL, 32'd0, RX_INCOMPLETE, 8'h00);
        // The unused status code behaves like incomplete and times out here.
        push_event(FN_POLL, 32'd10001, RX_UNUSED, 8'h00);
        // Exactly the timeout elapsed is not yet a timeout.
        push_event(FN_POLL, 32'd20001, RX_INCOMPLETE, 8'h00);
        push_event(FN_POLL, 32'd20002, RX_INVALID, 8'h00);
        // Id zero matches the reset value of the last received id.
        push_event(FN_POLL, 32'd20003, RX_VALID, 8'h00);
        // A poll while sending does nothing.
        push_event(FN_POLL, 32'd20004, RX_VALID, 8'h05);
        // Receive window opened just before the time counter wraps.
        push_event(FN_TX_DONE, 32'hFFFF_FFF0, RX_INCOMPLETE, 8'h00);
        push_event(FN_POLL, 32'h0000_0010, RX_INCOMPLETE, 8'h00);
        push_event(FN_POLL, 32'h0000_0011, RX_VALID, 8'hFF);
        // The unused function code leaves the state alone.
        push_event(FN_UNUSED, $urandom, 2'($urandom_range(0, 3)), ID_BITS'($urandom));
        push_event(FN_TX_DONE, 32'd100, RX_INCOMPLETE, 8'h00);
        // Same id again: a repeat, so the previous packet goes out again.
        push_event(FN_POLL, 32'd101, RX_VALID, 8'hFF);
        push_event(FN_START, 32'd200, RX_INCOMPLETE, 8'h00);
        push_event(FN_POLL, 32'd10201, RX_INCOMPLETE, 8'h00);

        // Master role with the tightest timeout and no retries tolerated,
        // slave settings at the other extreme.
        settle();
        program_link(1'b1, 20'd1, 20'd1000000, 7'd0, 7'd127);
        push_event(FN_START, 32'd0, RX_INCOMPLETE, 8'h00);
        push_event(FN_POLL, 32'd1, RX_INCOMPLETE, 8'h00);
        push_event(FN_POLL, 32'd2, RX_INCOMPLETE, 8'h00);
        push_event(FN_TX_DONE, 32'd1000, RX_INCOMPLETE, 8'h00);
        push_event(FN_POLL, 32'd1001, RX_INCOMPLETE, 8'h00);
        push_event(FN_POLL, 32'd1002, RX_INCOMPLETE, 8'h00);
        push_event(FN_POLL, 32'd1003, RX_INCOMPLETE, 8'h00);
        push_event(FN_TX_DONE, 32'hFFFF_FFFF, RX_INCOMPLETE, 8'h00);
        push_event(FN_POLL, 32'hFFFF_FFFF, RX_VALID, 8'h00);
        push_event(FN_TX_DONE, 32'd0, RX_INCOMPLETE, 8'h00);
        push_event(FN_POLL, 32'd0, RX_INVALID, 8'h00);

        // Random phases, each with its own register settings. Most traffic
        // is well-formed exchanges; the rest is arbitrary events.
        for (p = 0; p < 6; p++) begin
            settle();
            m    = 1'($urandom_range(0, 1));
            mt   = TMO_BITS'($urandom_range(1, 300));
            st   = TMO_BITS'($urandom_range(1, 300));
            mr   = RETRY_BITS'($urandom_range(0, 4));
            sr   = RETRY_BITS'($urandom_range(0, 4));
            span = 300;
            case (p)
                0: m = 1'b1;
                1: m = 1'b0;
                2: begin
                    mt   = 20'd1000000;
                    st   = 20'd1000000;
                    mr   = 7'd127;
                    sr   = 7'd127;
                    span = 1000000;
                end
                3: begin
                    mt   = 20'd1;
                    st   = 20'd1;
                    mr   = 7'd0;
                    sr   = 7'd0;
                    span = 4;
                end
                5: begin
                    // The closing phase runs at full rate on both sides.
                    sender_idles   = 1'b0;
                    receiver_idles = 1'b0;
                end
                default: ;
            endcase
            program_link(m, mt, st, mr, sr);
            if (p == 1) begin
                hold_off_req = 1'b1;
            end
            quota = events_sent + PHASE_EVENTS;
            while (events_sent < quota) begin
                if ($urandom_range(0, 9) < 8) begin
                    // One exchange: optional start, a send from ready, the
                    // transmit-finished event, a few polls while the packet
                    // is still arriving, then one way the window closes.
                    if ($urandom_range(0, 7) == 0) begin
                        push_event(FN_START, clock_us, RX_INCOMPLETE, peer_id);
                    end
                    if (role_master || $urandom_range(0, 1) == 1) begin
                        push_event(FN_POLL, clock_us, RX_INCOMPLETE, peer_id);
                    end
                    clock_us += $urandom_range(0, span);
                    push_event(FN_TX_DONE, clock_us, RX_INCOMPLETE, peer_id);
                    polls = $urandom_range(0, 3);
                    repeat (polls) begin
                        clock_us += $urandom_range(0, span / 2);
                        push_event(FN_POLL, clock_us,
                                   ($urandom_range(0, 1) == 1) ? RX_INCOMPLETE : RX_UNUSED,
                                   ID_BITS'($urandom));
                    end
                    ending = $urandom_range(0, 9);
                    clock_us += $urandom_range(0, span / 2);
                    if (ending < 5) begin
                        // The peer answers with a new packet.
                        peer_id++;
                        push_event(FN_POLL, clock_us, RX_VALID, peer_id);
                    end else if (ending < 7) begin
                        // The peer missed our packet and repeats its own.
                        push_event(FN_POLL, clock_us, RX_VALID, peer_id);
                    end else if (ending == 7) begin
                        push_event(FN_POLL, clock_us, RX_INVALID, ID_BITS'($urandom));
                    end else if (ending == 8) begin
                        // Nothing arrives before the timeout runs out.
                        clock_us += span + $urandom_range(1, span);
                        push_event(FN_POLL, clock_us, RX_INCOMPLETE, ID_BITS'($urandom));
                    end
                end else begin
                    // Arbitrary event, sometimes dragging the time base to a
                    // random point so that it also wraps.
                    t = $urandom;
                    if ($urandom_range(0, 1) == 1) begin
                        clock_us = t;
                    end
                    push_event(2'($urandom_range(0, 3)), t, 2'($urandom_range(0, 3)),
                               ID_BITS'($urandom));
                end
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("link_retry_timeout_controller regression: pass");
        end else begin
            $display("link_retry_timeout_controller regression: fail");
        end
        $finish;
    end

endmodule

>>> link_retry_timeout_controller.f
design/lrtc_pkg.sv
design/link_retry_timeout_controller.sv
tb/lrtc_result_checker.sv
tb/tb.sv
